### sv/srp_pkg.sv
// Shared types and codes of the skyline rectangle packer.
package srp_pkg;

   typedef struct packed {
      logic [12:0] rect_width;
      logic [12:0] rect_height;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] place_x;
      logic [11:0] place_y;
   } rsp_item_type;

   localparam logic [1:0] STATUS_PLACED     = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE   = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

   localparam logic [1:0] CSR_ATLAS_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_ATLAS_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PADDING      = 2'd2;

   localparam int CSR_DATA_BITS = 13;
   localparam int PAD_BITS      = 8;

endpackage

### sv/srp_ram.sv
// Generic single-write, single-read memory with a registered read port.
module srp_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/skyline_rect_packer_unit.sv
// Top level of the skyline rectangle packer: search sequencer and table rebuild.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+-----------------------------
//  request | start, busy, req_item               | taken when start and !busy
//  result  | rsp_valid, rsp_item                 | one-cycle strobe, no stall
//  config  | csr_write, csr_index, csr_data      | written when csr_write and !busy
//
// The search reads one table entry per cycle from the segment memory: for each
// start segment it reads on through every further segment that the box spans.
// A decision state follows; an item that places a box then copies the table into
// the other bank before it returns the result. Reset, like a write of the atlas
// width, leaves one full-width segment at once. The result strobe cannot be held
// off; busy falls in the cycle that carries it.
module skyline_rect_packer_unit
   import srp_pkg::*;
#(
   parameter int MAX_SEGMENTS = 256,
   parameter int COORD_BITS   = 13
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   output rsp_item_type             rsp_item,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int C  = COORD_BITS;
   localparam int IB = $clog2(MAX_SEGMENTS);
   localparam int CB = $clog2(MAX_SEGMENTS + 1);
   localparam int WB = ((C > 14) ? C : 14) + 2;
   localparam int EW = 3 * C;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_COPY   = 3'd3;
   localparam logic [2:0] S_FLUSH  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [C-1:0]       aw_ff, aw_in, ah_ff, ah_in;
   logic [PAD_BITS-1:0] pad_ff, pad_in;
   logic [CB-1:0]      count_ff, count_in;
   logic               bank_ff, bank_in, fresh_ff, fresh_in;
   logic [WB-1:0]      w_ff, w_in, h_ff, h_in;
   logic [IB-1:0]      i_ff, i_in, j_ff, j_in;
   logic               first_ff, first_in;
   logic [C-1:0]       y_ff, y_in, sx_ff, sx_in, sw_ff, sw_in;
   logic signed [WB-1:0] rem_ff, rem_in;
   logic               found_ff, found_in;
   logic [IB-1:0]      best_ff, best_in;
   logic [WB-1:0]      btop_ff, btop_in;
   logic [C-1:0]       bw_ff, bw_in, bx_ff, bx_in, by_ff, by_in;
   logic               boxd_ff, boxd_in, trim_ff, trim_in;
   logic               pv_ff, pv_in;
   logic [C-1:0]       pdx_ff, pdx_in, pdy_ff, pdy_in, pdw_ff, pdw_in;
   logic [IB-1:0]      wptr_ff, wptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic [IB-1:0]      rd_addr;
   logic [EW-1:0]      ram_rdata;
   logic               wr_en;
   logic [C-1:0]       d_x, d_y, d_w;

   // Scan datapath.
   logic               xfail, hfail, fail, more;
   logic [C-1:0]       y_cur, sx_cur, sw_cur;
   logic signed [WB-1:0] rem_cur;
   logic [WB-1:0]      top_cur;
   logic               better;

   // Rebuild datapath.
   logic               e_valid, e_merge;
   logic [C-1:0]       e_x, e_y, e_w;
   logic [WB-1:0]      bend;
   logic signed [WB-1:0] nw;
   logic [WB-1:0]      place_x_sum, place_y_sum;

   srp_ram #(
      .WIDTH (EW),
      .DEPTH (2 * MAX_SEGMENTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({~bank_ff, wptr_ff}),
      .wr_data ({pdx_ff, pdy_ff, pdw_ff}),
      .rd_addr ({bank_ff, rd_addr}),
      .rd_data (ram_rdata)
   );

   // A freshly reset skyline is one segment that lives only in the registers.
   assign d_x = fresh_ff ? '0 : ram_rdata[EW-1:2*C];
   assign d_y = fresh_ff ? '0 : ram_rdata[2*C-1:C];
   assign d_w = fresh_ff ? aw_ff : ram_rdata[C-1:0];

   always_comb begin
      xfail   = (WB'(d_x) + w_ff) > WB'(aw_ff);
      y_cur   = first_ff ? d_y : ((d_y > y_ff) ? d_y : y_ff);
      hfail   = (WB'(y_cur) + h_ff) > WB'(ah_ff);
      rem_cur = (first_ff ? $signed(w_ff) : rem_ff) - $signed(WB'(d_w));
      sx_cur  = first_ff ? d_x : sx_ff;
      sw_cur  = first_ff ? d_w : sw_ff;
      fail    = (first_ff && xfail) || hfail;
      more    = !fail && (rem_cur > 0);
      top_cur = WB'(y_cur) + h_ff;
      better  = !found_ff || (top_cur < btop_ff) ||
                ((top_cur == btop_ff) && (sw_cur < bw_ff));
      bend    = WB'(bx_ff) + w_ff;
      nw      = $signed(WB'(d_x) + WB'(d_w)) - $signed(bend);
      place_x_sum = WB'(bx_ff) + WB'(pad_ff);
      place_y_sum = WB'(by_ff) + WB'(pad_ff);
   end

   always_comb begin
      state_in     = state_ff;
      aw_in        = aw_ff;
      ah_in        = ah_ff;
      pad_in       = pad_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      fresh_in     = fresh_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      first_in     = first_ff;
      y_in         = y_ff;
      sx_in        = sx_ff;
      sw_in        = sw_ff;
      rem_in       = rem_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      btop_in      = btop_ff;
      bw_in        = bw_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      boxd_in      = boxd_ff;
      trim_in      = trim_ff;
      pv_in        = pv_ff;
      pdx_in       = pdx_ff;
      pdy_in       = pdy_ff;
      pdw_in       = pdw_ff;
      wptr_in      = wptr_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      rd_addr      = j_ff;
      wr_en        = 1'b0;
      e_valid      = 1'b0;
      e_merge      = 1'b0;
      e_x          = d_x;
      e_y          = d_y;
      e_w          = d_w;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (csr_write) begin
               unique case (csr_index)
                  CSR_ATLAS_WIDTH: begin
                     aw_in    = C'(csr_data);
                     count_in = CB'(1);
                     fresh_in = 1'b1;
                  end
                  CSR_ATLAS_HEIGHT: ah_in  = C'(csr_data);
                  CSR_PADDING:      pad_in = csr_data[PAD_BITS-1:0];
                  default: ;
               endcase
            end
            if (start) begin
               w_in     = WB'(req_item.rect_width) + WB'({pad_ff, 1'b0});
               h_in     = WB'(req_item.rect_height) + WB'({pad_ff, 1'b0});
               i_in     = '0;
               j_in     = '0;
               first_in = 1'b1;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            if (more && ((CB'(j_ff) + CB'(1)) < count_ff)) begin
               // The box spans further: fetch the next segment of this start.
               j_in     = j_ff + IB'(1);
               rd_addr  = j_ff + IB'(1);
               first_in = 1'b0;
               y_in     = y_cur;
               rem_in   = rem_cur;
               sx_in    = sx_cur;
               sw_in    = sw_cur;
            end else begin
               if (!fail && !more && better) begin
                  found_in = 1'b1;
                  best_in  = i_ff;
                  btop_in  = top_cur;
                  bw_in    = sw_cur;
                  bx_in    = sx_cur;
                  by_in    = y_cur;
               end
               if ((CB'(i_ff) + CB'(1)) < count_ff) begin
                  i_in     = i_ff + IB'(1);
                  j_in     = i_ff + IB'(1);
                  rd_addr  = i_ff + IB'(1);
                  first_in = 1'b1;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            rd_addr = '0;
            if (!found_ff) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{status: STATUS_NO_SPACE, place_x: '0, place_y: '0};
               state_in     = S_IDLE;
            end else if (w_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{status: STATUS_PLACED, place_x: place_x_sum[11:0],
                                place_y: place_y_sum[11:0]};
               state_in     = S_IDLE;
            end else if (count_ff >= CB'(MAX_SEGMENTS)) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{status: STATUS_TABLE_FULL, place_x: '0, place_y: '0};
               state_in     = S_IDLE;
            end else begin
               j_in     = '0;
               boxd_in  = 1'b0;
               trim_in  = 1'b0;
               pv_in    = 1'b0;
               wptr_in  = '0;
               state_in = S_COPY;
            end
         end

         S_COPY: begin
            if ((j_ff == best_ff) && !boxd_ff) begin
               // Emit the box first and read the same entry again.
               e_valid = 1'b1;
               e_merge = pv_ff;
               e_x     = bx_ff;
               e_y     = C'(WB'(by_ff) + h_ff);
               e_w     = C'(w_ff);
               boxd_in = 1'b1;
               trim_in = 1'b1;
               rd_addr = j_ff;
            end else begin
               if (j_ff < best_ff) begin
                  e_valid = 1'b1;
               end else if (trim_ff) begin
                  if (WB'(d_x) == bend) begin
                     e_valid = 1'b1;
                     e_merge = 1'b1;
                     trim_in = 1'b0;
                  end else if (nw > 0) begin
                     e_valid = 1'b1;
                     e_merge = 1'b1;
                     e_x     = C'(bend);
                     e_w     = C'(nw);
                     trim_in = 1'b0;
                  end
               end else begin
                  e_valid = 1'b1;
               end
               if ((CB'(j_ff) + CB'(1)) < count_ff) begin
                  j_in    = j_ff + IB'(1);
                  rd_addr = j_ff + IB'(1);
               end else begin
                  state_in = S_FLUSH;
               end
            end
            // Adjacent segments of equal height around the box fold into one.
            if (e_valid) begin
               if (pv_ff && e_merge && (pdy_ff == e_y)) begin
                  pdw_in = pdw_ff + e_w;
               end else begin
                  if (pv_ff) begin
                     wr_en   = 1'b1;
                     wptr_in = wptr_ff + IB'(1);
                  end
                  pv_in  = 1'b1;
                  pdx_in = e_x;
                  pdy_in = e_y;
                  pdw_in = e_w;
               end
            end
         end

         S_FLUSH: begin
            wr_en        = 1'b1;
            count_in     = CB'(wptr_ff) + CB'(1);
            bank_in      = ~bank_ff;
            fresh_in     = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_item_in  = '{status: STATUS_PLACED, place_x: place_x_sum[11:0],
                             place_y: place_y_sum[11:0]};
            state_in     = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         aw_ff        <= C'(1024);
         ah_ff        <= C'(1024);
         pad_ff       <= '0;
         count_ff     <= CB'(1);
         bank_ff      <= 1'b0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         pad_ff       <= pad_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      first_ff    <= first_in;
      y_ff        <= y_in;
      sx_ff       <= sx_in;
      sw_ff       <= sw_in;
      rem_ff      <= rem_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      btop_ff     <= btop_in;
      bw_ff       <= bw_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      boxd_ff     <= boxd_in;
      trim_ff     <= trim_in;
      pv_ff       <= pv_in;
      pdx_ff      <= pdx_in;
      pdy_ff      <= pdy_in;
      pdw_ff      <= pdw_in;
      wptr_ff     <= wptr_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### sv/srp_checker.sv
// Port-level checks of the packer, bound to the top level.
module srp_checker
   import srp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   // An accepted item makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("block went idle without a result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status == STATUS_PLACED ||
                     rsp_item.status == STATUS_NO_SPACE ||
                     rsp_item.status == STATUS_TABLE_FULL))
      else $error("undefined status code");

   a_zero_place: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != STATUS_PLACED) |->
         (rsp_item.place_x == '0 && rsp_item.place_y == '0))
      else $error("placement corner set on a failed item");

endmodule

bind skyline_rect_packer_unit srp_checker u_srp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
